// ----- rtl/scs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the sigma-clip statistics core.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CNT_W    = 6;
  localparam int SUM_W    = 30;
  localparam int ABS_W    = 25;
  localparam int PROD_W   = 50;
  localparam int SQ_W     = 54;
  localparam int ROOT_W   = 27;
  localparam int SD_W     = 25;
  localparam int THR_W    = 8;
  localparam int LIM_W    = 33;
  localparam int SQRT_STEPS = SQ_W / 2;

  localparam logic [THR_W-1:0] THR_RESET = 8'd32;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_KEPT    = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } item_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] kept_value;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic        [SAMPLE_W-1:0] std_dev;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic                       overflowed;
    logic                       end_of_run;
  } result_t;

  // run summary handed from front to back
  typedef struct packed {
    logic        [CNT_W-1:0]    count;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic                       dropped;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_MEAN_GO,
    B_MEAN,
    B_SQ_ADDR,
    B_SQ_ABS,
    B_SQ_MUL,
    B_SQ_ACC,
    B_VAR_GO,
    B_VAR,
    B_SQRT,
    B_LIM,
    B_KP_ADDR,
    B_KP_ABS,
    B_KP_CMP,
    B_SUMMARY,
    B_EM_ADDR,
    B_EM_DATA,
    B_DONE
  } back_state_t;

endpackage

// ----- rtl/scs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/scs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_div
// Restoring unsigned divider, one quotient bit per cycle. Shared by the
// mean and variance steps.
// ----------------------------------------------------------------------------
module scs_div
  import scs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SQ_W-1:0]  quotient
);

  logic [SQ_W-1:0]  quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W-1:0] steps;
  logic             active;
  logic [CNT_W:0]   shifted;
  logic             fits;

  assign shifted  = {rem, quo[SQ_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= '0;
      end else if (active) begin
        steps <= steps + 1'b1;
        if (steps == CNT_W'(SQ_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      quo <= {quo[SQ_W-2:0], fits};
      rem <= fits ? CNT_W'(shifted - {1'b0, dvs}) : shifted[CNT_W-1:0];
    end
  end

endmodule

// ----- rtl/scs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_front
// Loads samples into the store, keeps running sum, min, max and count,
// and hands a run summary to the back end on the last sample.
// ----------------------------------------------------------------------------
module scs_front
  import scs_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [SAMPLE_W-1:0] ram_wdata,
  output logic                job_valid,
  output job_t                job,
  input  logic                job_take,
  input  logic                run_done
);

  logic [CNT_W-1:0]           count, count_next;
  logic signed [SUM_W-1:0]    sum, sum_next;
  logic signed [SAMPLE_W-1:0] mn, mn_next, mx, mx_next;
  logic                       drop, drop_next;
  logic                       busy;
  logic                       accept, stored;

  assign accept = push && !full;
  assign stored = count < CNT_W'(DEPTH);
  assign full   = busy;

  assign ram_we    = accept && stored;
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = item.sample;

  always_comb begin
    count_next = count;
    sum_next   = sum;
    mn_next    = mn;
    mx_next    = mx;
    drop_next  = drop;
    if (stored) begin
      count_next = count + 1'b1;
      sum_next   = sum + SUM_W'(item.sample);
      if (count == '0) begin
        mn_next = item.sample;
        mx_next = item.sample;
      end else begin
        if (item.sample < mn) mn_next = item.sample;
        if (item.sample > mx) mx_next = item.sample;
      end
    end else begin
      drop_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      mn        <= '0;
      mx        <= '0;
      drop      <= 1'b0;
      busy      <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) job_valid <= 1'b0;
      if (run_done) busy <= 1'b0;
      if (accept) begin
        if (item.is_last) begin
          job       <= '{count_next, sum_next, mn_next, mx_next, drop_next};
          job_valid <= 1'b1;
          busy      <= 1'b1;
          count     <= '0;
          sum       <= '0;
          mn        <= '0;
          mx        <= '0;
          drop      <= 1'b0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
          mn    <= mn_next;
          mx    <= mx_next;
          drop  <= drop_next;
        end
      end
    end
  end

endmodule

// ----- rtl/scs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_back
// Sequencer for mean, variance, square root and clipping passes, with the
// result register on its output side.
// ----------------------------------------------------------------------------
module scs_back
  import scs_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [THR_W-1:0]    threshold,
  input  logic                job_valid,
  input  job_t                job,
  output logic                job_take,
  output logic                run_done,
  output logic [AW-1:0]       ram_raddr,
  input  logic [SAMPLE_W-1:0] ram_rdata,
  output logic                empty,
  input  logic                pop,
  output result_t             result
);

  back_state_t state, state_next;

  job_t                       run;
  logic [CNT_W-1:0]           idx, nres, emitted;
  logic signed [SAMPLE_W-1:0] mean;
  logic [ABS_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [SQ_W-1:0]            sq, rad;
  logic [ROOT_W-1:0]          root;
  logic [ROOT_W+2:0]          rem;
  logic [4:0]                 steps;
  logic [LIM_W-1:0]           lim;
  logic [DEPTH-1:0]           kept;
  logic                       out_valid;

  logic                       div_start, div_done;
  logic [SQ_W-1:0]            div_dividend, div_q;
  logic [SUM_W-1:0]           sum_mag;
  logic signed [ABS_W-1:0]    diff;
  logic [ABS_W-1:0]           diff_mag;
  logic [ROOT_W+4:0]          rem_sh, trial;
  logic                       root_bit;
  logic                       last_idx, slot_free, keep_now;
  logic                       out_load;
  result_t                    out_next;

  assign sum_mag  = run.sum[SUM_W-1] ? SUM_W'(-run.sum) : run.sum;
  assign diff     = ABS_W'(signed'(ram_rdata)) - ABS_W'(mean);
  assign diff_mag = diff[ABS_W-1] ? ABS_W'(-diff) : diff;
  assign rem_sh   = {rem, rad[SQ_W-1 -: 2]};
  assign trial    = {3'b000, root, 2'b01};
  assign root_bit = rem_sh >= trial;
  assign last_idx = idx == run.count - 1'b1;
  assign slot_free = !out_valid || pop;
  assign keep_now = LIM_W'({mag, 4'b0000}) <= lim;
  assign empty     = !out_valid;
  assign ram_raddr = idx[AW-1:0];

  scs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (run.count),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:    if (job_valid) state_next = B_MEAN_GO;
      B_MEAN_GO: state_next = B_MEAN;
      B_MEAN:    if (div_done) state_next = B_SQ_ADDR;
      B_SQ_ADDR: state_next = B_SQ_ABS;
      B_SQ_ABS:  state_next = B_SQ_MUL;
      B_SQ_MUL:  state_next = B_SQ_ACC;
      B_SQ_ACC:  state_next = last_idx ? B_VAR_GO : B_SQ_ADDR;
      B_VAR_GO:  state_next = B_VAR;
      B_VAR:     if (div_done) state_next = B_SQRT;
      B_SQRT:    if (steps == 5'(SQRT_STEPS - 1)) state_next = B_LIM;
      B_LIM:     state_next = B_KP_ADDR;
      B_KP_ADDR: state_next = B_KP_ABS;
      B_KP_ABS:  state_next = B_KP_CMP;
      B_KP_CMP:  state_next = last_idx ? B_SUMMARY : B_KP_ADDR;
      B_SUMMARY: begin
        if (slot_free) state_next = (nres == '0) ? B_DONE : B_EM_ADDR;
      end
      B_EM_ADDR: state_next = B_EM_DATA;
      B_EM_DATA: begin
        if (!kept[idx[AW-1:0]]) begin
          state_next = B_EM_ADDR;
        end else if (slot_free) begin
          state_next = (emitted + 1'b1 == nres) ? B_DONE : B_EM_ADDR;
        end
      end
      B_DONE:    state_next = B_IDLE;
      default:   state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_take     = 1'b0;
    run_done     = 1'b0;
    div_start    = 1'b0;
    div_dividend = sq;
    out_load     = 1'b0;
    out_next     = '0;
    case (state)
      B_IDLE:    job_take = job_valid;
      B_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = SQ_W'(sum_mag);
      end
      B_VAR_GO:  div_start = 1'b1;
      B_SUMMARY: begin
        out_load            = slot_free;
        out_next.kind       = KIND_SUMMARY;
        out_next.mean_value = mean;
        out_next.std_dev    = root[SAMPLE_W-1:0];
        out_next.minimum    = run.minimum;
        out_next.maximum    = run.maximum;
        out_next.overflowed = run.dropped;
        out_next.end_of_run = nres == '0;
      end
      B_EM_DATA: begin
        out_load            = slot_free && kept[idx[AW-1:0]];
        out_next.kind       = KIND_KEPT;
        out_next.kept_value = ram_rdata;
        out_next.end_of_run = emitted + 1'b1 == nres;
      end
      B_DONE:    run_done = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= out_next;
    case (state)
      B_IDLE: begin
        run <= job;
        idx <= '0;
        sq  <= '0;
      end
      B_MEAN: begin
        if (div_done) begin
          mean <= run.sum[SUM_W-1] ? SAMPLE_W'(-div_q) : div_q[SAMPLE_W-1:0];
        end
      end
      B_SQ_ABS: mag <= diff_mag;
      B_SQ_MUL: prod <= mag * mag;
      B_SQ_ACC: begin
        sq  <= sq + SQ_W'(prod);
        idx <= idx + 1'b1;
      end
      B_VAR: begin
        rad   <= div_q;
        rem   <= '0;
        root  <= '0;
        steps <= '0;
      end
      B_SQRT: begin
        rad   <= {rad[SQ_W-3:0], 2'b00};
        root  <= {root[ROOT_W-2:0], root_bit};
        rem   <= root_bit ? (ROOT_W+3)'(rem_sh - trial) : rem_sh[ROOT_W+2:0];
        steps <= steps + 1'b1;
      end
      B_LIM: begin
        lim  <= LIM_W'(threshold * root[SD_W-1:0]);
        idx  <= '0;
        nres <= '0;
      end
      B_KP_ABS: mag <= diff_mag;
      B_KP_CMP: begin
        kept[idx[AW-1:0]] <= keep_now;
        nres <= nres + CNT_W'(keep_now);
        idx  <= last_idx ? '0 : idx + 1'b1;
      end
      B_SUMMARY: emitted <= '0;
      B_EM_DATA: begin
        if (!kept[idx[AW-1:0]]) begin
          idx <= idx + 1'b1;
        end else if (slot_free) begin
          idx     <= idx + 1'b1;
          emitted <= emitted + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/sigma_clip_statistics_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_clip_statistics_core
// Sigma-clipping outlier rejection over a run of fixed-point samples.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  input    | push / full            | item   (item_t)
//  results  | pop / empty            | result (result_t)
//  config   | cfg_valid / cfg_ready  | cfg_data (clip threshold)
//
// Samples load at one per cycle. After the last sample, full stays high
// while the back end runs: a 54-step divider for the mean, a pass over the
// stored samples (address, abs, multiply, accumulate) for the squared
// deviations, the divider again for the variance, the square root, a clip
// pass, then the summary and an emit pass. A stall on pop holds the emit
// pass. Reset is synchronous; the threshold returns to 2.0.
// ----------------------------------------------------------------------------
module sigma_clip_statistics_core
  import scs_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  item_t            item,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [THR_W-1:0]    threshold;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic                job_valid, job_take, run_done;
  job_t                job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  scs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scs_front #(.DEPTH(DEPTH), .AW(AW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .run_done  (run_done)
  );

  scs_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .run_done  (run_done),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- sim/scs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker
// Watches the sample, result and threshold channels of the sigma-clip core,
// keeps its own copy of the run statistics and checks every result item.
// ----------------------------------------------------------------------------
module scs_checker
  import scs_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  item_t            item,
  input  logic             empty,
  input  logic             pop,
  input  result_t          result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data,
  output int               fail_count,
  output int               results_due
);

  logic signed [SAMPLE_W-1:0] stored [DEPTH];
  int                         n_stored;
  longint                     run_sum;
  logic signed [SAMPLE_W-1:0] run_min, run_max;
  logic                       dropped;
  logic [THR_W-1:0]           threshold;
  result_t                    expected_results[$];

  assign results_due = expected_results.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root, probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned abs_dev(longint x, longint m);
    longint d;
    d = x - m;
    return (d < 0) ? -d : d;
  endfunction

  // fold one accepted sample into the run; on the last one queue the results
  task automatic absorb_sample(item_t it);
    longint            mean;
    longint unsigned   sq, var_q, sd, lim;
    bit                keep [DEPTH];
    int                n_keep, k;
    result_t           r;
    if (n_stored < DEPTH) begin
      stored[n_stored] = it.sample;
      if (n_stored == 0) begin
        run_min = it.sample;
        run_max = it.sample;
      end else begin
        if (it.sample < run_min) run_min = it.sample;
        if (it.sample > run_max) run_max = it.sample;
      end
      n_stored++;
      run_sum += longint'(it.sample);
    end else begin
      dropped = 1'b1;
    end
    if (!it.is_last) return;

    mean = run_sum / longint'(n_stored);
    sq = 0;
    for (int i = 0; i < n_stored; i++) begin
      sq += abs_dev(longint'(stored[i]), mean) * abs_dev(longint'(stored[i]), mean);
    end
    var_q  = sq / longint'(n_stored);
    sd     = floor_root(var_q);
    lim    = longint'(threshold) * sd;
    n_keep = 0;
    for (int i = 0; i < n_stored; i++) begin
      keep[i] = (16 * abs_dev(longint'(stored[i]), mean)) <= lim;
      if (keep[i]) n_keep++;
    end

    r            = '0;
    r.kind       = KIND_SUMMARY;
    r.mean_value = mean[SAMPLE_W-1:0];
    r.std_dev    = sd[SAMPLE_W-1:0];
    r.minimum    = run_min;
    r.maximum    = run_max;
    r.overflowed = dropped;
    r.end_of_run = (n_keep == 0);
    expected_results.insert(expected_results.size(), r);
    k = 0;
    for (int i = 0; i < n_stored; i++) begin
      if (keep[i]) begin
        k++;
        r            = '0;
        r.kind       = KIND_KEPT;
        r.kept_value = stored[i];
        r.end_of_run = (k == n_keep);
        expected_results.insert(expected_results.size(), r);
      end
    end
    n_stored = 0;
    run_sum  = 0;
    run_min  = '0;
    run_max  = '0;
    dropped  = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      n_stored   = 0;
      run_sum    = 0;
      run_min    = '0;
      run_max    = '0;
      dropped    = 1'b0;
      threshold  = THR_RESET;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result item %p", $time, result);
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                       $time, want, result);
          end
        end
      end
      if (push && !full) absorb_sample(item);
      if (cfg_valid && cfg_ready) threshold = cfg_data;
    end
  end

endmodule

// ----- sim/tb_sigma_clip_statistics_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sigma_clip_statistics_core
// Streams directed and random sample sets through the sigma-clip core under
// several clip thresholds, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sigma_clip_statistics_core;
  import scs_pkg::*;

  localparam int DEPTH      = 32;
  localparam int WATCHDOG   = 5000;
  localparam int DRAIN_WAIT = 60;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  item_t            item;
  logic             empty;
  logic             pop;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;
  int               fail_count;
  int               results_due;

  bit calm;
  int items_sent, sets_sent, thresholds_used, quiet_cycles;

  sigma_clip_statistics_core #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  scs_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: pop high except for short random stalls
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      stall = 0;
      pop <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(0, 2);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic last);
    item_t it;
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    it.sample  = s;
    it.is_last = last;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
    if (last) sets_sent++;
  endtask

  // everything delivered, then let the back end settle before a register write
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresholds_used++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_W'($urandom);
      1:       return $signed(SAMPLE_W'($urandom_range(0, 4095))) - 24'sd2048;
      2:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return $signed(SAMPLE_W'($urandom_range(0, 255))) + 24'sh1000;
    endcase
  endfunction

  task automatic send_set(int len);
    for (int i = 0; i < len; i++) send_item(rand_sample(), i == len - 1);
  endtask

  initial begin
    int len;
    rst       = 1'b1;
    push      = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    items_sent = 0; sets_sent = 0; thresholds_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset threshold: single sample, extremes, then overflowing store
    send_item(24'sh7FFFFF, 1'b1);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh7FFFFF, 1'b0);
    send_item(24'sh000000, 1'b0);
    send_item(24'sh000100, 1'b1);
    send_item(-24'sd5, 1'b0);
    send_item(-24'sd5, 1'b1);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(SAMPLE_W'(i * 37 - 600), i == DEPTH + 1);

    // zero threshold: nothing kept unless deviation is zero
    write_threshold(8'd0);
    send_item(24'sh001000, 1'b0);
    send_item(24'sh002000, 1'b1);
    send_item(24'sh000400, 1'b0);
    send_item(24'sh000400, 1'b1);

    write_threshold(8'd255);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh7FFFFF, 1'b0);
    send_item(24'sh000001, 1'b1);

    // random phases with threshold changes
    while (items_sent < 180) begin
      case ($urandom_range(0, 3))
        0:       write_threshold(8'd32);
        1:       write_threshold(8'd16);
        default: write_threshold(THR_W'($urandom));
      endcase
      repeat ($urandom_range(2, 5)) begin
        if (items_sent >= 180) break;
        if (items_sent > 150) calm = 1'b1;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 1, DEPTH + 3)
                                          : $urandom_range(1, 8);
        send_set(len);
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d samples in %0d sets over %0d threshold settings,",
             items_sent, sets_sent, thresholds_used);
    $display("including store overflow, zero spread and all-rejected sets.");
    if (fail_count == 0 && results_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
